[sv/tcp_pkg.sv]
// ---------------------------------------------------------------------------
// tcp_pkg
// shared types and width helpers for the triangle closest point pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

  // per item flags travelling alongside the datapath
  typedef struct packed {
    logic       vld;
    logic       pos;
    logic       ins;
    logic [2:0] neg;
  } tcp_ctl_t;

  function automatic int dot_w(input int w);
    return 2 * w + 3;
  endfunction

  function automatic int det_w(input int w);
    return 4 * w + 7;
  endfunction

  function automatic int num_w(input int w);
    return 5 * w + 9;
  endfunction

endpackage

`default_nettype wire

[sv/tcp_if.sv]
// ---------------------------------------------------------------------------
// tcp channel interfaces
// valid/ready channels for triangle words and result words
// ---------------------------------------------------------------------------
`default_nettype none

interface tcp_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] v0_x;
  logic signed [W-1:0] v0_y;
  logic signed [W-1:0] v0_z;
  logic signed [W-1:0] v1_x;
  logic signed [W-1:0] v1_y;
  logic signed [W-1:0] v1_z;
  logic signed [W-1:0] v2_x;
  logic signed [W-1:0] v2_y;
  logic signed [W-1:0] v2_z;
  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

interface tcp_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic                valid_res;
  logic signed [W:0]   near_x;
  logic signed [W:0]   near_y;
  logic signed [W:0]   near_z;
  logic [2*W-1:0]      dist_sq;
  logic                inside_res;
  modport source (output valid, valid_res, near_x, near_y, near_z, dist_sq, inside_res,
                  input ready);
  modport sink (input valid, valid_res, near_x, near_y, near_z, dist_sq, inside_res,
                output ready);
endinterface

`default_nettype wire

[sv/tcp_dots.sv]
// ---------------------------------------------------------------------------
// tcp_dots
// edge vectors and the five dot products, two register stages
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_dots #(
  parameter int W = 16,
  localparam int EW = W + 1,
  localparam int PW = 2 * EW,
  localparam int DW = tcp_pkg::dot_w(W)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [W-1:0]  p0_i [3],
  input  logic signed [W-1:0]  p1_i [3],
  input  logic signed [W-1:0]  p2_i [3],
  output logic                 vld_o,
  output logic signed [DW-1:0] d11_o,
  output logic signed [DW-1:0] d12_o,
  output logic signed [DW-1:0] d22_o,
  output logic signed [DW-1:0] d01_o,
  output logic signed [DW-1:0] d02_o,
  output logic signed [EW-1:0] e1_o [3],
  output logic signed [EW-1:0] e2_o [3],
  output logic signed [W-1:0]  p0_o [3]
);

  logic signed [EW-1:0] e1_c [3];
  logic signed [EW-1:0] e2_c [3];
  logic                 vld1_r, vld2_r;
  logic signed [PW-1:0] s11_r [3];
  logic signed [PW-1:0] s12_r [3];
  logic signed [PW-1:0] s22_r [3];
  logic signed [PW-1:0] s01_r [3];
  logic signed [PW-1:0] s02_r [3];
  logic signed [EW-1:0] e1a_r [3];
  logic signed [EW-1:0] e2a_r [3];
  logic signed [W-1:0]  p0a_r [3];
  logic signed [DW-1:0] d11_r, d12_r, d22_r, d01_r, d02_r;
  logic signed [EW-1:0] e1b_r [3];
  logic signed [EW-1:0] e2b_r [3];
  logic signed [W-1:0]  p0b_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_c[i] = EW'(p1_i[i]) - EW'(p0_i[i]);
      e2_c[i] = EW'(p2_i[i]) - EW'(p0_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s11_r[i] <= PW'(e1_c[i]) * PW'(e1_c[i]);
        s12_r[i] <= PW'(e1_c[i]) * PW'(e2_c[i]);
        s22_r[i] <= PW'(e2_c[i]) * PW'(e2_c[i]);
        s01_r[i] <= PW'(p0_i[i]) * PW'(e1_c[i]);
        s02_r[i] <= PW'(p0_i[i]) * PW'(e2_c[i]);
        e1a_r[i] <= e1_c[i];
        e2a_r[i] <= e2_c[i];
        p0a_r[i] <= p0_i[i];
      end
      d11_r <= DW'(s11_r[0]) + DW'(s11_r[1]) + DW'(s11_r[2]);
      d12_r <= DW'(s12_r[0]) + DW'(s12_r[1]) + DW'(s12_r[2]);
      d22_r <= DW'(s22_r[0]) + DW'(s22_r[1]) + DW'(s22_r[2]);
      d01_r <= DW'(s01_r[0]) + DW'(s01_r[1]) + DW'(s01_r[2]);
      d02_r <= DW'(s02_r[0]) + DW'(s02_r[1]) + DW'(s02_r[2]);
      e1b_r <= e1a_r;
      e2b_r <= e2a_r;
      p0b_r <= p0a_r;
    end
  end

  assign vld_o = vld2_r;
  assign d11_o = d11_r;
  assign d12_o = d12_r;
  assign d22_o = d22_r;
  assign d01_o = d01_r;
  assign d02_o = d02_r;
  assign e1_o  = e1b_r;
  assign e2_o  = e2b_r;
  assign p0_o  = p0b_r;

endmodule

`default_nettype wire

[sv/tcp_solve.sv]
// ---------------------------------------------------------------------------
// tcp_solve
// determinant, barycentric numerators and per axis numerator magnitude
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_solve #(
  parameter int W = 16,
  localparam int EW  = W + 1,
  localparam int DW  = tcp_pkg::dot_w(W),
  localparam int MW  = 2 * DW,
  localparam int LW  = tcp_pkg::det_w(W),
  localparam int LS  = (LW + 1) / 2,
  localparam int LHW = LW - LS,
  localparam int HPW = LHW + EW,
  localparam int LPW = LS + 1 + EW,
  localparam int NW  = tcp_pkg::num_w(W)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [DW-1:0] d11_i,
  input  logic signed [DW-1:0] d12_i,
  input  logic signed [DW-1:0] d22_i,
  input  logic signed [DW-1:0] d01_i,
  input  logic signed [DW-1:0] d02_i,
  input  logic signed [EW-1:0] e1_i [3],
  input  logic signed [EW-1:0] e2_i [3],
  input  logic signed [W-1:0]  p0_i [3],
  output tcp_pkg::tcp_ctl_t    ctl_o,
  output logic [LW-1:0]        det_o,
  output logic [NW-1:0]        mag_o [3],
  output logic signed [W-1:0]  p0_o [3]
);

  // vertex and edge carry
  logic signed [EW-1:0] e1_3_r [3], e2_3_r [3], e1_4_r [3], e2_4_r [3];
  logic signed [W-1:0]  p0_3_r [3], p0_4_r [3], p0_5_r [3], p0_6_r [3], p0_7_r [3];
  logic                 vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;
  // stage 3 products
  logic signed [MW-1:0] ma_r, mb_r, mc_r, md_r, me_r, mf_r;
  // stage 4
  logic signed [LW-1:0] det4_r, l1_r, l2_r;
  // stage 5
  logic signed [HPW-1:0] h1_r [3], h2_r [3];
  logic signed [LPW-1:0] w1_r [3], w2_r [3];
  logic signed [LW-1:0]  det5_r, det6_r, det7_r;
  logic                  pos5_r, pos6_r, pos7_r, ins5_r, ins6_r, ins7_r;
  // stage 6 and 7
  logic signed [NW-1:0]  num_r [3];
  logic [NW-1:0]         mag_r [3];
  logic [2:0]            neg7_r;

  logic signed [LHW-1:0] l1h_c, l2h_c;
  logic signed [LS:0]    l1l_c, l2l_c;
  logic signed [LW:0]    lsum_c;
  logic                  pos_c, ins_c;

  always_comb begin
    l1h_c  = signed'(l1_r[LW-1:LS]);
    l2h_c  = signed'(l2_r[LW-1:LS]);
    l1l_c  = signed'({1'b0, l1_r[LS-1:0]});
    l2l_c  = signed'({1'b0, l2_r[LS-1:0]});
    lsum_c = (LW+1)'(l1_r) + (LW+1)'(l2_r);
    pos_c  = !det4_r[LW-1] && (det4_r != '0);
    ins_c  = !l1_r[LW-1] && !l2_r[LW-1] && (lsum_c <= (LW+1)'(det4_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld_i;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= MW'(d11_i) * MW'(d22_i);
      mb_r   <= MW'(d12_i) * MW'(d12_i);
      mc_r   <= MW'(d02_i) * MW'(d12_i);
      md_r   <= MW'(d01_i) * MW'(d22_i);
      me_r   <= MW'(d01_i) * MW'(d12_i);
      mf_r   <= MW'(d02_i) * MW'(d11_i);
      e1_3_r <= e1_i;
      e2_3_r <= e2_i;
      p0_3_r <= p0_i;

      det4_r <= LW'(ma_r) - LW'(mb_r);
      l1_r   <= LW'(mc_r) - LW'(md_r);
      l2_r   <= LW'(me_r) - LW'(mf_r);
      e1_4_r <= e1_3_r;
      e2_4_r <= e2_3_r;
      p0_4_r <= p0_3_r;

      for (int i = 0; i < 3; i++) begin
        h1_r[i] <= HPW'(l1h_c) * HPW'(e1_4_r[i]);
        h2_r[i] <= HPW'(l2h_c) * HPW'(e2_4_r[i]);
        w1_r[i] <= LPW'(l1l_c) * LPW'(e1_4_r[i]);
        w2_r[i] <= LPW'(l2l_c) * LPW'(e2_4_r[i]);
      end
      det5_r <= det4_r;
      pos5_r <= pos_c;
      ins5_r <= ins_c;
      p0_5_r <= p0_4_r;

      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NW'((HPW+1)'(h1_r[i]) + (HPW+1)'(h2_r[i])) << LS)
                    + NW'(w1_r[i]) + NW'(w2_r[i]);
      end
      det6_r <= det5_r;
      pos6_r <= pos5_r;
      ins6_r <= ins5_r;
      p0_6_r <= p0_5_r;

      for (int i = 0; i < 3; i++) begin
        neg7_r[i] <= num_r[i][NW-1];
        mag_r[i]  <= num_r[i][NW-1] ? NW'(-num_r[i]) : NW'(num_r[i]);
      end
      det7_r <= det6_r;
      pos7_r <= pos6_r;
      ins7_r <= ins6_r;
      p0_7_r <= p0_6_r;
    end
  end

  assign ctl_o = '{vld: vld7_r, pos: pos7_r, ins: ins7_r, neg: neg7_r};
  assign det_o = det7_r;
  assign mag_o = mag_r;
  assign p0_o  = p0_7_r;

endmodule

`default_nettype wire

[sv/tcp_div.sv]
// ---------------------------------------------------------------------------
// tcp_div
// pipelined restoring divider, one quotient bit per stage on all three axes
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_div #(
  parameter int W = 16,
  localparam int LW = tcp_pkg::det_w(W),
  localparam int NW = tcp_pkg::num_w(W),
  localparam int QB = W + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tcp_pkg::tcp_ctl_t   ctl_i,
  input  logic [LW-1:0]       det_i,
  input  logic [NW-1:0]       mag_i [3],
  input  logic signed [W-1:0] p0_i [3],
  output tcp_pkg::tcp_ctl_t   ctl_o,
  output logic [QB-1:0]       q_o [3],
  output logic signed [W-1:0] p0_o [3]
);

  logic [NW-1:0]       rem_r [QB][3];
  logic [QB-1:0]       quo_r [QB][3];
  logic [LW-1:0]       det_r [QB];
  logic signed [W-1:0] p0_r  [QB][3];
  tcp_pkg::tcp_ctl_t   ctl_r [QB];

  logic [NW-1:0] rin_c [QB][3];
  logic [QB-1:0] qin_c [QB][3];
  logic [LW-1:0] din_c [QB];
  logic [NW-1:0] dsh_c [QB];
  logic [NW-1:0] rnx_c [QB][3];
  logic [QB-1:0] qnx_c [QB][3];
  logic          ge_c  [QB][3];

  always_comb begin
    rin_c[0] = mag_i;
    for (int i = 0; i < 3; i++) qin_c[0][i] = '0;
    din_c[0] = det_i;
    for (int s = 1; s < QB; s++) begin
      rin_c[s] = rem_r[s-1];
      qin_c[s] = quo_r[s-1];
      din_c[s] = det_r[s-1];
    end
    for (int s = 0; s < QB; s++) begin
      dsh_c[s] = NW'(din_c[s]) << (QB - 1 - s);
      for (int i = 0; i < 3; i++) begin
        ge_c[s][i]  = rin_c[s][i] >= dsh_c[s];
        rnx_c[s][i] = ge_c[s][i] ? rin_c[s][i] - dsh_c[s] : rin_c[s][i];
        qnx_c[s][i] = qin_c[s][i] | (QB'(ge_c[s][i]) << (QB - 1 - s));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QB; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int s = 1; s < QB; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QB; s++) begin
        rem_r[s] <= rnx_c[s];
        quo_r[s] <= qnx_c[s];
        det_r[s] <= din_c[s];
      end
      p0_r[0] <= p0_i;
      for (int s = 1; s < QB; s++) p0_r[s] <= p0_r[s-1];
    end
  end

  assign ctl_o = ctl_r[QB-1];
  assign q_o   = quo_r[QB-1];
  assign p0_o  = p0_r[QB-1];

  // remainder left after the last bit must be below the divisor
  a_rem_below_det: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r[QB-1].vld && ctl_r[QB-1].pos) |->
      (rem_r[QB-1][0] < NW'(det_r[QB-1]) && rem_r[QB-1][1] < NW'(det_r[QB-1]) &&
       rem_r[QB-1][2] < NW'(det_r[QB-1])))
    else $error("divider remainder not below determinant");

endmodule

`default_nettype wire

[sv/tcp_fin.sv]
// ---------------------------------------------------------------------------
// tcp_fin
// signed quotient plus vertex with saturation, squared length, result register
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_fin #(
  parameter int W = 16,
  localparam int QB  = W + 1,
  localparam int NRW = W + 1,
  localparam int SW  = W + 3,
  localparam int SQW = 2 * NRW,
  localparam int SMW = SQW + 2,
  localparam int DSW = 2 * W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  tcp_pkg::tcp_ctl_t     ctl_i,
  input  logic [QB-1:0]         q_i [3],
  input  logic signed [W-1:0]   p0_i [3],
  output logic                  vld_o,
  output logic                  valid_res_o,
  output logic signed [NRW-1:0] near_o [3],
  output logic [DSW-1:0]        dist_o,
  output logic                  inside_o
);

  localparam logic signed [SW-1:0]  SLO  = -(SW'(1) <<< W);
  localparam logic signed [SW-1:0]  SHI  = (SW'(1) <<< W) - SW'(1);
  localparam logic signed [NRW-1:0] NLO  = NRW'(SLO);
  localparam logic signed [NRW-1:0] NHI  = NRW'(SHI);
  localparam logic [SMW-1:0]        DMAX = (SMW'(1) << DSW) - SMW'(1);

  logic signed [SW-1:0]  qs_c [3];
  logic signed [SW-1:0]  sv_c [3];
  logic signed [NRW-1:0] nr_nxt [3];
  logic [SMW-1:0]        sum_c;

  logic                  vldA_r, vldB_r, out_vld_r;
  logic                  posA_r, posB_r, insA_r, insB_r;
  logic signed [NRW-1:0] nearA_r [3], nearB_r [3];
  logic [SQW-1:0]        sq_r [3];
  logic                  valid_res_r, inside_r;
  logic signed [NRW-1:0] near_r [3];
  logic [DSW-1:0]        dist_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs_c[i] = signed'(SW'(q_i[i]));
      sv_c[i] = SW'(p0_i[i]) + (ctl_i.neg[i] ? -qs_c[i] : qs_c[i]);
      if (!ctl_i.pos) begin
        nr_nxt[i] = '0;
      end else if (sv_c[i] < SLO) begin
        nr_nxt[i] = NLO;
      end else if (sv_c[i] > SHI) begin
        nr_nxt[i] = NHI;
      end else begin
        nr_nxt[i] = NRW'(sv_c[i]);
      end
    end
    sum_c = SMW'(sq_r[0]) + SMW'(sq_r[1]) + SMW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldA_r    <= 1'b0;
      vldB_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vldA_r    <= ctl_i.vld;
      vldB_r    <= vldA_r;
      out_vld_r <= vldB_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nearA_r <= nr_nxt;
      posA_r  <= ctl_i.pos;
      insA_r  <= ctl_i.pos && ctl_i.ins;

      for (int i = 0; i < 3; i++) sq_r[i] <= SQW'(nearA_r[i]) * SQW'(nearA_r[i]);
      nearB_r <= nearA_r;
      posB_r  <= posA_r;
      insB_r  <= insA_r;

      near_r      <= nearB_r;
      dist_r      <= (sum_c > DMAX) ? DSW'(DMAX) : DSW'(sum_c);
      valid_res_r <= posB_r;
      inside_r    <= insB_r;
    end
  end

  assign vld_o       = out_vld_r;
  assign valid_res_o = valid_res_r;
  assign near_o      = near_r;
  assign dist_o      = dist_r;
  assign inside_o    = inside_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !valid_res_r) |->
      (near_r[0] == '0 && near_r[1] == '0 && near_r[2] == '0 && dist_r == '0 && !inside_r))
    else $error("degenerate triangle word carries nonzero fields");

  a_inside_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && inside_r) |-> valid_res_r)
    else $error("inside flag set on degenerate triangle");

  a_zero_dist_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && dist_r == '0) |->
      (near_r[0] == '0 && near_r[1] == '0 && near_r[2] == '0))
    else $error("zero squared length with nonzero point");

endmodule

`default_nettype wire

[sv/triangle_closest_point_to_origin_top.sv]
// ---------------------------------------------------------------------------
// triangle_closest_point_to_origin_top
// closest point to the origin on a triangle's plane, fully pipelined
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_ch    in   valid / ready  v0_x..v2_z, signed Q8.8 vertices
//  out_ch   out  valid / ready  valid_res, near_x/y/z, dist_sq, inside_res
//
//  one triangle accepted per cycle while no result word waits
//  the divider resolves one quotient bit per stage
//  all stages advance together; a waiting result word freezes the pipe
//  reset clears the valid bits and the divider's per item flags only
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_closest_point_to_origin_top #(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tcp_in_if.sink     in_ch,
  tcp_out_if.source  out_ch
);

  localparam int W  = COORD_BITS;
  localparam int EW = W + 1;
  localparam int DW = tcp_pkg::dot_w(W);
  localparam int LW = tcp_pkg::det_w(W);
  localparam int NW = tcp_pkg::num_w(W);
  localparam int QB = W + 1;

  logic                en;
  logic signed [W-1:0] p0_c [3], p1_c [3], p2_c [3];

  logic                 dt_vld;
  logic signed [DW-1:0] d11, d12, d22, d01, d02;
  logic signed [EW-1:0] dt_e1 [3], dt_e2 [3];
  logic signed [W-1:0]  dt_p0 [3];

  tcp_pkg::tcp_ctl_t    sv_ctl;
  logic [LW-1:0]        sv_det;
  logic [NW-1:0]        sv_mag [3];
  logic signed [W-1:0]  sv_p0 [3];

  tcp_pkg::tcp_ctl_t    dv_ctl;
  logic [QB-1:0]        dv_q [3];
  logic signed [W-1:0]  dv_p0 [3];

  logic signed [W:0]    near [3];

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign p0_c[0] = in_ch.v0_x;
  assign p0_c[1] = in_ch.v0_y;
  assign p0_c[2] = in_ch.v0_z;
  assign p1_c[0] = in_ch.v1_x;
  assign p1_c[1] = in_ch.v1_y;
  assign p1_c[2] = in_ch.v1_z;
  assign p2_c[0] = in_ch.v2_x;
  assign p2_c[1] = in_ch.v2_y;
  assign p2_c[2] = in_ch.v2_z;

  tcp_dots #(.W(W)) u_dots (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_ch.valid),
    .p0_i  (p0_c),
    .p1_i  (p1_c),
    .p2_i  (p2_c),
    .vld_o (dt_vld),
    .d11_o (d11),
    .d12_o (d12),
    .d22_o (d22),
    .d01_o (d01),
    .d02_o (d02),
    .e1_o  (dt_e1),
    .e2_o  (dt_e2),
    .p0_o  (dt_p0)
  );

  tcp_solve #(.W(W)) u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (dt_vld),
    .d11_i (d11),
    .d12_i (d12),
    .d22_i (d22),
    .d01_i (d01),
    .d02_i (d02),
    .e1_i  (dt_e1),
    .e2_i  (dt_e2),
    .p0_i  (dt_p0),
    .ctl_o (sv_ctl),
    .det_o (sv_det),
    .mag_o (sv_mag),
    .p0_o  (sv_p0)
  );

  tcp_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (sv_ctl),
    .det_i (sv_det),
    .mag_i (sv_mag),
    .p0_i  (sv_p0),
    .ctl_o (dv_ctl),
    .q_o   (dv_q),
    .p0_o  (dv_p0)
  );

  tcp_fin #(.W(W)) u_fin (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (dv_ctl),
    .q_i         (dv_q),
    .p0_i        (dv_p0),
    .vld_o       (out_ch.valid),
    .valid_res_o (out_ch.valid_res),
    .near_o      (near),
    .dist_o      (out_ch.dist_sq),
    .inside_o    (out_ch.inside_res)
  );

  assign out_ch.near_x = near[0];
  assign out_ch.near_y = near[1];
  assign out_ch.near_z = near[2];

endmodule

`default_nettype wire
